### rtl/pid_pkg.sv
// Package: shared widths, types, register indexes and sequencer states for the PID step unit
package pid_pkg;

    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int GAIN_W  = 24;
    localparam int LIM_W   = 31;
    localparam int DT_W    = 16;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 31;

    // shared multiplier: signed data operand times zero-extended gain or time step
    localparam int MUL_AW  = DATA_W;
    localparam int MUL_BW  = GAIN_W + 1;
    localparam int PROD_W  = MUL_AW + MUL_BW;

    // serial divider: |error change| << FRAC_W over the time step
    localparam int DIV_NW  = DATA_W + FRAC_W;
    localparam int DIV_CW  = $clog2(DIV_NW + 1);

    // drive accumulator: three products plus headroom
    localparam int ACC_W   = PROD_W + 2;

    localparam logic [GAIN_W-1:0] GAIN_P_RST = GAIN_W'(334234);
    localparam logic [GAIN_W-1:0] GAIN_I_RST = GAIN_W'(0);
    localparam logic [GAIN_W-1:0] GAIN_D_RST = GAIN_W'(15729);
    localparam logic [LIM_W-1:0]  LIMIT_RST  = LIM_W'(1966080);
    localparam logic [DT_W-1:0]   DT_RST     = DT_W'(66);

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic [CFG_AW-1:0] {
        CFG_GAIN_P    = 3'd0,
        CFG_GAIN_I    = 3'd1,
        CFG_GAIN_D    = 3'd2,
        CFG_LIMIT     = 3'd3,
        CFG_TIME_STEP = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_INC,
        S_INT,
        S_CLAMP,
        S_MP,
        S_MI,
        S_AI,
        S_WDIV,
        S_MD,
        S_AD,
        S_DRV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic neg;
    } t_div_status;

endpackage

### rtl/pid_in_if.sv
// Interface: update/clear transaction channel into the PID step unit
interface pid_in_if import pid_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  cmd;
    t_data setpoint;
    t_data measurement;

    modport source (output valid, cmd, setpoint, measurement, input ready);
    modport sink   (input valid, cmd, setpoint, measurement, output ready);
endinterface

### rtl/pid_out_if.sv
// Interface: result transaction channel out of the PID step unit
interface pid_out_if import pid_pkg::*; ();
    logic  valid;
    logic  ready;
    t_data drive;
    logic  drive_saturated;
    logic  integral_clamped;

    modport source (output valid, drive, drive_saturated, integral_clamped, input ready);
    modport sink   (input valid, drive, drive_saturated, integral_clamped, output ready);
endinterface

### rtl/pid_mul.sv
// Shared signed multiplier with registered product
module pid_mul import pid_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MUL_AW-1:0] i_a,
    input  logic signed [MUL_BW-1:0] i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

### rtl/pid_div.sv
// Serial restoring divider, one quotient bit per cycle, sign-magnitude result
module pid_div import pid_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [DATA_W:0] i_diff,
    input  logic [DT_W-1:0]        i_divisor,
    output t_div_status            o_stat,
    output logic [DIV_NW-1:0]      o_quot
);

    logic [DIV_NW-1:0] r_q;
    logic [DT_W-1:0]   r_rem;
    logic [DT_W-1:0]   r_div;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_neg;

    logic [DATA_W-1:0] mag;
    logic [DT_W:0]     trial;
    logic [DT_W:0]     trial_sub;
    logic              q_bit;

    // |diff| never exceeds 2^DATA_W - 1, so the low DATA_W bits hold it
    assign mag       = i_diff[DATA_W] ? DATA_W'((DATA_W+1)'(0) - i_diff)
                                      : i_diff[DATA_W-1:0];
    assign trial     = {r_rem, r_q[DIV_NW-1]};
    assign trial_sub = trial - {1'b0, r_div};
    assign q_bit     = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CW'(DIV_NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - DIV_CW'(1);
            if (r_cnt == DIV_CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= {mag, {FRAC_W{1'b0}}};
            r_neg <= i_diff[DATA_W];
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_NW-2:0], q_bit};
            r_rem <= q_bit ? trial_sub[DT_W-1:0] : trial[DT_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.neg  = r_neg;
    assign o_quot      = r_q;

endmodule

### rtl/pid_controller_step_unit.sv
// Top level: PID controller step, sequenced over one shared multiplier and a serial divider
// Sequence: an update runs the error setup, then the divider steps (the integral, P and I
//   products overlap them), then the derivative product and drive; a clear goes straight to done.
// Flow: one transaction at a time; the next is accepted once the result sits in the output
//   register; a stalled one holds the sequencer.
// Reset (synchronous, active low): register defaults, zero integral and previous error.
module pid_controller_step_unit import pid_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pid_in_if.sink            i_in,
    pid_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    // ---------------- configuration registers ----------------
    logic [GAIN_W-1:0] r_gain_p;
    logic [GAIN_W-1:0] r_gain_i;
    logic [GAIN_W-1:0] r_gain_d;
    logic [LIM_W-1:0]  r_limit;
    logic [DT_W-1:0]   r_time_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= GAIN_P_RST;
            r_gain_i    <= GAIN_I_RST;
            r_gain_d    <= GAIN_D_RST;
            r_limit     <= LIMIT_RST;
            r_time_step <= DT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN_P:    r_gain_p    <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:    r_gain_i    <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:    r_gain_d    <= i_cfg_data[GAIN_W-1:0];
                CFG_LIMIT:     r_limit     <= i_cfg_data[LIM_W-1:0];
                CFG_TIME_STEP: r_time_step <= i_cfg_data[DT_W-1:0];
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    // ---------------- sequencer state ----------------
    t_state r_state;
    t_state n_state;

    logic in_xfer;
    logic out_load;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // ---------------- datapath registers ----------------
    t_data                 r_sp;
    t_data                 r_meas;
    t_data                 r_err;
    t_data                 r_last_err;
    t_data                 r_integral;
    t_data                 r_deriv;
    logic signed [DATA_W:0] r_sum;
    logic signed [ACC_W-1:0] r_acc;
    logic                  r_sat;
    logic                  r_clamped;

    t_data r_res_drive;
    logic  r_res_sat;
    logic  r_res_clamp;

    logic  r_out_valid;
    t_data r_out_drive;
    logic  r_out_sat;
    logic  r_out_clamp;

    // ---------------- shared units ----------------
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;

    logic                   div_start;
    logic signed [DATA_W:0] div_diff;
    logic [DT_W-1:0]        div_divisor;
    t_div_status            div_stat;
    logic [DIV_NW-1:0]      div_quot;

    pid_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // a zero time step divides by one
    assign div_diff    = {r_err[DATA_W-1], r_err} - {r_last_err[DATA_W-1], r_last_err};
    assign div_divisor = (r_time_step == '0) ? DT_W'(1) : r_time_step;

    pid_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_diff    (div_diff),
        .i_divisor (div_divisor),
        .o_stat    (div_stat),
        .o_quot    (div_quot)
    );

    // ---------------- combinational arithmetic ----------------
    // error: setpoint minus measurement, clipped to the data range
    logic signed [DATA_W:0] err_wide;
    logic                   err_ovf;
    t_data                  err_sat;

    assign err_wide = {r_sp[DATA_W-1], r_sp} - {r_meas[DATA_W-1], r_meas};
    assign err_ovf  = err_wide[DATA_W] ^ err_wide[DATA_W-1];
    assign err_sat  = err_ovf ? (err_wide[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                                  : {1'b0, {(DATA_W-1){1'b1}}})
                              : err_wide[DATA_W-1:0];

    // integral step: (error * dt) >> F, arithmetic shift floors
    logic signed [PROD_W-1:0] inc_shift;
    logic signed [DATA_W:0]   sum_next;

    assign inc_shift = prod >>> FRAC_W;
    assign sum_next  = {r_integral[DATA_W-1], r_integral} + inc_shift[DATA_W:0];

    logic signed [DATA_W:0] lim_pos;
    logic signed [DATA_W:0] lim_neg;

    assign lim_pos = $signed({2'b00, r_limit});
    assign lim_neg = -lim_pos;

    // derivative: sign-magnitude quotient clipped to the data range
    logic  deriv_ovf;
    t_data deriv_val;

    always_comb begin
        if (div_stat.neg) begin
            deriv_ovf = (|div_quot[DIV_NW-1:DATA_W])
                     || (div_quot[DATA_W-1] && (|div_quot[DATA_W-2:0]));
            deriv_val = deriv_ovf ? {1'b1, {(DATA_W-1){1'b0}}}
                                  : DATA_W'(0) - div_quot[DATA_W-1:0];
        end else begin
            deriv_ovf = |div_quot[DIV_NW-1:DATA_W-1];
            deriv_val = deriv_ovf ? {1'b0, {(DATA_W-1){1'b1}}}
                                  : div_quot[DATA_W-1:0];
        end
    end

    // drive: accumulator >> F (floor), clipped to the data range
    logic  drv_ovf;
    t_data drv_val;

    assign drv_ovf = !((&r_acc[ACC_W-1:FRAC_W+DATA_W-1]) || !(|r_acc[ACC_W-1:FRAC_W+DATA_W-1]));
    assign drv_val = drv_ovf ? (r_acc[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                               : {1'b0, {(DATA_W-1){1'b1}}})
                             : r_acc[FRAC_W+DATA_W-1:FRAC_W];

    // ---------------- next-state logic ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = (i_in.cmd == CMD_CLEAR) ? S_DONE : S_ERR;
                end
            end
            S_ERR:   n_state = S_INC;
            S_INC:   n_state = S_INT;
            S_INT:   n_state = S_CLAMP;
            S_CLAMP: n_state = S_MP;
            S_MP:    n_state = S_MI;
            S_MI:    n_state = S_AI;
            S_AI:    n_state = S_WDIV;
            S_WDIV: begin
                if (!div_stat.busy) begin
                    n_state = S_MD;
                end
            end
            S_MD:    n_state = S_AD;
            S_AD:    n_state = S_DRV;
            S_DRV:   n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_INC: begin
                mul_a     = r_err;
                mul_b     = $signed({{(MUL_BW-DT_W){1'b0}}, r_time_step});
                div_start = 1'b1;
            end
            S_MP: begin
                mul_a = r_err;
                mul_b = $signed({1'b0, r_gain_p});
            end
            S_MI: begin
                mul_a = r_integral;
                mul_b = $signed({1'b0, r_gain_i});
            end
            S_MD: begin
                mul_a = r_deriv;
                mul_b = $signed({1'b0, r_gain_d});
            end
            S_DONE: begin
                // result register free, or being emptied this cycle
                out_load = !r_out_valid || o_out.ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- controller state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_last_err <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_xfer && i_in.cmd == CMD_CLEAR) begin
                        r_integral <= '0;
                        r_last_err <= '0;
                    end
                end
                S_INT: r_last_err <= r_err;
                S_CLAMP: begin
                    if (r_sum > lim_pos) begin
                        r_integral <= lim_pos[DATA_W-1:0];
                    end else if (r_sum < lim_neg) begin
                        r_integral <= lim_neg[DATA_W-1:0];
                    end else begin
                        r_integral <= r_sum[DATA_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- working registers ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    r_sp        <= i_in.setpoint;
                    r_meas      <= i_in.measurement;
                    r_res_drive <= '0;
                    r_res_sat   <= 1'b0;
                    r_res_clamp <= 1'b0;
                end
            end
            S_ERR: begin
                r_err     <= err_sat;
                r_sat     <= err_ovf;
                r_clamped <= 1'b0;
            end
            S_INT:   r_sum <= sum_next;
            S_CLAMP: r_clamped <= (r_sum > lim_pos) || (r_sum < lim_neg);
            S_MI:    r_acc <= ACC_W'(prod);
            S_AI:    r_acc <= r_acc + ACC_W'(prod);
            S_WDIV: begin
                if (!div_stat.busy) begin
                    r_deriv <= deriv_val;
                    r_sat   <= r_sat | deriv_ovf;
                end
            end
            S_AD:    r_acc <= r_acc + ACC_W'(prod);
            S_DRV: begin
                r_res_drive <= drv_val;
                r_res_sat   <= r_sat | drv_ovf;
                r_res_clamp <= r_clamped;
            end
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_drive <= r_res_drive;
            r_out_sat   <= r_res_sat;
            r_out_clamp <= r_res_clamp;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.drive            = r_out_drive;
    assign o_out.drive_saturated  = r_out_sat;
    assign o_out.integral_clamped = r_out_clamp;

    // ---------------- assertions ----------------
    // a clear transaction zeroes the controller state on the next cycle
    a_clear_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in.cmd == CMD_CLEAR) |=> (r_integral == '0 && r_last_err == '0))
        else $error("clear did not zero integral/previous error");

    // the derivative product is only issued once the divider has finished
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MD) |-> !div_stat.busy)
        else $error("derivative used while divider busy");

    // a new result only appears after the sequencer has finished a transaction
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result valid without completed transaction");

endmodule

### sim/pid_controller_step_unit_test.sv
// Testbench: self-checking stimulus and bit-exact drive prediction for the PID step unit
`timescale 1ns / 1ps

module pid_controller_step_unit_test;
    import pid_pkg::*;

    localparam int  CYCLE_LIMIT   = 2_000_000;
    // Leave margin for the sequencer to go idle before touching registers.
    localparam int  SETTLE_CYCLES = 64;
    localparam int  RAND_ITEMS    = 180;       // per register setting, 9 settings in all
    localparam t_data DATA_MAX    = t_data'({1'b0, {(DATA_W-1){1'b1}}});
    localparam t_data DATA_MIN    = t_data'({1'b1, {(DATA_W-1){1'b0}}});
    localparam t_data ONE_Q       = t_data'(1 << FRAC_W);

    typedef struct packed {
        t_data drive;
        logic  saturated;
        logic  clamped;
    } t_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_idx;
    logic [CFG_DW-1:0] i_cfg_data;

    pid_in_if  in_ch ();
    pid_out_if out_ch ();

    pid_controller_step_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the register file, tracked as writes go out.
    logic [GAIN_W-1:0] kp_reg    = GAIN_P_RST;
    logic [GAIN_W-1:0] ki_reg    = GAIN_I_RST;
    logic [GAIN_W-1:0] kd_reg    = GAIN_D_RST;
    logic [LIM_W-1:0]  limit_reg = LIMIT_RST;
    logic [DT_W-1:0]   dt_reg    = DT_RST;

    // Shadow controller state.
    t_data integral_acc = '0;
    t_data prev_error   = '0;

    t_result pending_drives [$];   // predicted results, oldest first
    t_result want;
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    int      src_idle_pct   = 34;
    int      snk_idle_pct   = 60;
    t_data   track_sp       = '0;

    // ------------------------------------------------------------------
    // Drive prediction
    // ------------------------------------------------------------------

    // Saturate to the data word; flag any clipping.
    function automatic longint clip_word(input longint v, inout bit hit);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (DATA_W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo) begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // One controller step: returns the expected result and advances the shadow state.
    // All math is held in 64 bits, which is exact at the default widths
    // (largest term is a 24-bit gain times a 32-bit value).
    function automatic t_result compute_drive(input logic cmd, input t_data sp,
                                              input t_data meas);
        t_result r;
        bit      hit;
        longint  err, sum, lim, dt, divisor, deriv, acc;
        r   = '0;
        hit = 1'b0;
        if (cmd == CMD_CLEAR) begin
            integral_acc = '0;
            prev_error   = '0;
            return r;
        end
        err = clip_word(longint'(sp) - longint'(meas), hit);
        dt  = longint'(dt_reg);
        // arithmetic shift floors toward minus infinity
        sum = longint'(integral_acc) + ((err * dt) >>> FRAC_W);
        lim = longint'(limit_reg);
        // landing exactly on a bound is not a clamp
        if (sum > lim) begin
            sum       = lim;
            r.clamped = 1'b1;
        end
        if (sum < -lim) begin
            sum       = -lim;
            r.clamped = 1'b1;
        end
        // zero time step: divide by one instead
        divisor = (dt != 0) ? dt : 64'sd1;
        // signed divide truncates toward zero
        deriv = clip_word(((err - longint'(prev_error)) * (64'sd1 <<< FRAC_W)) / divisor,
                          hit);
        acc = longint'(kp_reg) * err + longint'(ki_reg) * sum + longint'(kd_reg) * deriv;
        r.drive      = t_data'(clip_word(acc >>> FRAC_W, hit));
        r.saturated  = hit;
        integral_acc = t_data'(sum);
        prev_error   = t_data'(err);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint got, input longint exp_v);
        $display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, exp_v);
        mismatch_count++;
    endtask

    // Every accepted result transaction is matched to the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_drives.size() == 0) begin
                report_mismatch("result with nothing pending", longint'(out_ch.drive), 0);
            end else begin
                want = pending_drives.pop_front();
                if (out_ch.drive !== want.drive)
                    report_mismatch("drive", longint'(out_ch.drive), longint'(want.drive));
                if (out_ch.drive_saturated !== want.saturated)
                    report_mismatch("drive_saturated", out_ch.drive_saturated, want.saturated);
                if (out_ch.integral_clamped !== want.clamped)
                    report_mismatch("integral_clamped", out_ch.integral_clamped, want.clamped);
            end
        end
    end

    // Sink backpressure: ready re-rolled every falling edge.
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Present one transaction (after random source gaps), hold until accepted,
    // then record the prediction. Returns just after the accepting edge.
    task automatic send_item(input logic cmd, input t_data sp, input t_data meas);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= cmd;
        in_ch.setpoint    <= sp;
        in_ch.measurement <= meas;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        pending_drives.push_back(compute_drive(cmd, sp, meas));
    endtask

    // Drop valid, wait for every predicted result, then let the sequencer go idle.
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input t_cfg_idx idx, input logic [CFG_DW-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_GAIN_P:    kp_reg    = val[GAIN_W-1:0];
            CFG_GAIN_I:    ki_reg    = val[GAIN_W-1:0];
            CFG_GAIN_D:    kd_reg    = val[GAIN_W-1:0];
            CFG_LIMIT:     limit_reg = val[LIM_W-1:0];
            CFG_TIME_STEP: dt_reg    = val[DT_W-1:0];
            default: ;
        endcase
    endtask

    // Full register set, written only with the block idle.
    task automatic program_regs(input logic [GAIN_W-1:0] gp, input logic [GAIN_W-1:0] gi,
                                input logic [GAIN_W-1:0] gd, input logic [LIM_W-1:0] lim,
                                input logic [DT_W-1:0] dt);
        settle();
        set_reg(CFG_GAIN_P,    CFG_DW'(gp));
        set_reg(CFG_GAIN_I,    CFG_DW'(gi));
        set_reg(CFG_GAIN_D,    CFG_DW'(gd));
        set_reg(CFG_LIMIT,     CFG_DW'(lim));
        set_reg(CFG_TIME_STEP, CFG_DW'(dt));
    endtask

    function automatic t_data corner_value();
        case ($urandom_range(5))
            0:       return DATA_MIN;
            1:       return DATA_MAX;
            2:       return '0;
            3:       return -1;
            4:       return 1;
            default: return ONE_Q;
        endcase
    endfunction

    // Gains spread over zero, realistic (up to ~4.0) and full scale.
    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(3))
            0:       return '0;
            1:       return GAIN_W'($urandom_range(1 << 18));
            2:       return GAIN_W'($urandom);
            default: return '1;
        endcase
    endfunction

    function automatic logic [LIM_W-1:0] pick_limit();
        case ($urandom_range(3))
            0:       return LIM_W'($urandom_range(1 << 16));
            1:       return LIM_W'($urandom_range(1 << 24));
            2:       return LIM_W'($urandom);
            default: return '1;
        endcase
    endfunction

    function automatic logic [DT_W-1:0] pick_dt();
        case ($urandom_range(4))
            0:       return DT_W'(1);
            1:       return '1;
            2:       return DT_W'($urandom_range(1, 256));
            default: return DT_W'($urandom_range(1, 65535));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset defaults: error saturation both ways, integral clamp at the default
    // limit, a clear with extreme (ignored) payload, and zero error.
    task automatic test_reset_defaults();
        send_item(CMD_UPDATE, '0, '0);
        send_item(CMD_UPDATE, ONE_Q, '0);
        send_item(CMD_UPDATE, DATA_MAX, DATA_MIN);
        send_item(CMD_UPDATE, DATA_MIN, DATA_MAX);
        send_item(CMD_CLEAR, DATA_MAX, DATA_MAX);
        send_item(CMD_UPDATE, -1, '0);
        send_item(CMD_UPDATE, DATA_MAX, DATA_MAX);
        send_item(CMD_UPDATE, DATA_MIN, DATA_MIN);
    endtask

    // Register extremes: everything at full scale, everything at zero
    // (zero time step and a zero limit), then unit gains with the smallest step.
    task automatic test_register_extremes();
        program_regs('1, '1, '1, '1, '1);
        send_item(CMD_UPDATE, DATA_MAX, DATA_MIN);
        send_item(CMD_UPDATE, DATA_MIN, DATA_MAX);
        send_item(CMD_UPDATE, t_data'(12345), t_data'(-6789));
        send_item(CMD_CLEAR, '0, '0);

        // zero time step: no integral growth, derivative divisor falls back to one
        program_regs('0, '0, '0, '0, '0);
        send_item(CMD_UPDATE, ONE_Q, '0);
        send_item(CMD_UPDATE, DATA_MIN, DATA_MAX);
        send_item(CMD_UPDATE, t_data'(3), '0);
        // zero error keeps the sum on the zero bound: no clamp flag
        send_item(CMD_UPDATE, t_data'(5), t_data'(5));

        program_regs(GAIN_W'(1 << FRAC_W), GAIN_W'(1 << FRAC_W), GAIN_W'(1 << FRAC_W),
                     LIM_W'(10 << FRAC_W), DT_W'(1));
        send_item(CMD_UPDATE, t_data'(2 << FRAC_W), '0);
        send_item(CMD_UPDATE, t_data'(-(2 << FRAC_W)), '0);
        send_item(CMD_CLEAR, DATA_MIN, DATA_MAX);
        send_item(CMD_UPDATE, t_data'(1), '0);
    endtask

    // Random traffic under one idle pattern, over three random register settings.
    // Most transactions follow a slowly moving setpoint with a measurement near it,
    // so the integral winds up and the derivative stays meaningful; the rest are
    // clears, raw random words and corner values.
    task automatic test_random_traffic(input int src_pct, input int snk_pct);
        int     pick;
        int     span;
        longint offset;
        t_data  meas;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        repeat (3) begin
            program_regs(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_dt());
            repeat (RAND_ITEMS) begin
                // occasionally hold off until the unit has fully drained
                if ($urandom_range(39) == 0)
                    settle();
                pick = $urandom_range(99);
                if (pick < 8) begin
                    send_item(CMD_CLEAR, t_data'($urandom), t_data'($urandom));
                end else if (pick < 20) begin
                    send_item(CMD_UPDATE, t_data'($urandom), t_data'($urandom));
                end else if (pick < 28) begin
                    send_item(CMD_UPDATE, corner_value(), corner_value());
                end else begin
                    if ($urandom_range(19) == 0)
                        track_sp = t_data'($urandom);
                    span   = $urandom_range(30);
                    offset = longint'($urandom_range(1 << span));
                    if ($urandom_range(1) == 1)
                        offset = -offset;
                    meas = t_data'(longint'(track_sp) - offset);
                    send_item(CMD_UPDATE, track_sp, meas);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_GAIN_P;
        i_cfg_data        = '0;
        in_ch.valid       = 1'b0;
        in_ch.cmd         = CMD_UPDATE;
        in_ch.setpoint    = '0;
        in_ch.measurement = '0;
        out_ch.ready      = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_random_traffic(34, 60);
        test_random_traffic(60, 34);
        test_random_traffic(0, 0);

        settle();
        if (mismatch_count == 0 && pending_drives.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sim.f
rtl/pid_pkg.sv
rtl/pid_in_if.sv
rtl/pid_out_if.sv
rtl/pid_mul.sv
rtl/pid_div.sv
rtl/pid_controller_step_unit.sv
sim/pid_controller_step_unit_test.sv
